[rtl/ssl_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and helpers for the setpoint step limiter.
// No dependencies; used by the interfaces and every module.
package ssl_pkg;

  localparam int POS_W    = 32;               // Q16.16 position
  localparam int MAG_W    = POS_W;            // |goal - now| fits in POS_W bits
  localparam int SQ_W     = 2 * MAG_W;        // one squared component
  localparam int SUM_W    = SQ_W + 2;         // sum of three squares
  localparam int LIM_W    = 31;               // step length limit
  localparam int LIM2_W   = 2 * LIM_W;
  localparam int PROD_W   = MAG_W + LIM_W;    // |d| * limit
  localparam int ROOT_W   = SUM_W / 2;        // floor(sqrt(sum))
  localparam int Q_W      = MAG_W;            // quotient never exceeds |d| when the step is limited
  localparam int SQRT_LAT = ROOT_W;           // one root bit per stage
  localparam int DIV_LAT  = Q_W;              // one quotient bit per stage
  localparam int PIPE_LAT = 4 + SQRT_LAT + DIV_LAT + 1;

  localparam int HEAD_W = 16;                 // Q2.13 yaw
  localparam int YLIM_W = 15;
  localparam int WRAP_W = HEAD_W + 2;
  localparam logic signed [WRAP_W-1:0] YAW_PI     = 18'sd25736;
  localparam logic signed [WRAP_W-1:0] YAW_TWO_PI = 18'sd51472;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_STEP_LIMIT    = 2'd1;
  localparam logic [LIM_W-1:0]  STEP_LIMIT_RESET = 31'd52429;
  localparam logic [YLIM_W-1:0] YAW_LIMIT_RESET  = 15'd4289;

  typedef struct packed {
    logic signed [POS_W-1:0]  goal_x;
    logic signed [POS_W-1:0]  goal_y;
    logic signed [POS_W-1:0]  goal_z;
    logic signed [HEAD_W-1:0] goal_heading;
    logic signed [POS_W-1:0]  now_x;
    logic signed [POS_W-1:0]  now_y;
    logic signed [POS_W-1:0]  now_z;
    logic signed [HEAD_W-1:0] now_heading;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  out_x;
    logic signed [POS_W-1:0]  out_y;
    logic signed [POS_W-1:0]  out_z;
    logic signed [HEAD_W-1:0] out_heading;
  } out_item_t;

  // Data that rides alongside the root and divider pipelines
  typedef struct packed {
    logic [2:0][POS_W-1:0]  goal;
    logic [2:0][POS_W-1:0]  now;
    logic [2:0]             neg;
    logic [HEAD_W-1:0]      heading;
    logic                   take_goal;
    logic [2:0][PROD_W-1:0] prod;
  } side_t;

  // Bring a yaw sum or difference into (-pi, pi]; one correction suffices
  function automatic logic signed [WRAP_W-1:0] yaw_wrap(input logic signed [WRAP_W-1:0] a);
    logic signed [WRAP_W-1:0] r;
    r = a;
    if (a > YAW_PI) begin
      r = a - YAW_TWO_PI;
    end else if (a <= -YAW_PI) begin
      r = a + YAW_TWO_PI;
    end
    return r;
  endfunction

endpackage

[rtl/ssl_if.sv]
`timescale 1ns / 1ps
// Handshake channels of the setpoint step limiter: item in, item out, config.
// Depends on ssl_pkg for the payload types.
interface ssl_in_if;
  logic               valid;
  logic               ready;
  ssl_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssl_out_if;
  logic               valid;
  logic               ready;
  ssl_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ssl_pkg::CFG_IDX_W-1:0]    index;
  logic [ssl_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/ssl_yaw.sv]
`timescale 1ns / 1ps
// Two-stage yaw path: wrap the difference, clamp it, add and wrap again.
// Depends on ssl_pkg.
module ssl_yaw (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ssl_pkg::HEAD_W-1:0] goal_heading,
  input  logic signed [ssl_pkg::HEAD_W-1:0] now_heading,
  input  logic [ssl_pkg::YLIM_W-1:0]        yaw_limit,
  output logic signed [ssl_pkg::HEAD_W-1:0] heading
);

  localparam int WRAP_W = ssl_pkg::WRAP_W;

  logic signed [ssl_pkg::WRAP_W-1:0] diff_raw;
  logic signed [ssl_pkg::HEAD_W-1:0] diff;
  logic signed [ssl_pkg::HEAD_W-1:0] base;
  logic signed [ssl_pkg::WRAP_W-1:0] lim;
  logic signed [ssl_pkg::WRAP_W-1:0] clamped;
  logic signed [ssl_pkg::WRAP_W-1:0] sum_wrapped;

  // First stage: wrapped difference
  assign diff_raw = ssl_pkg::yaw_wrap(WRAP_W'(goal_heading) - WRAP_W'(now_heading));

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= diff_raw[ssl_pkg::HEAD_W-1:0];
      base <= now_heading;
    end
  end

  // Second stage: clamp to the limit, add and wrap
  always_comb begin
    lim     = $signed({{(WRAP_W-ssl_pkg::YLIM_W){1'b0}}, yaw_limit});
    clamped = WRAP_W'(diff);
    if (clamped > lim) begin
      clamped = lim;
    end
    if (clamped < -lim) begin
      clamped = -lim;
    end
    sum_wrapped = ssl_pkg::yaw_wrap(WRAP_W'(base) + clamped);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      heading <= sum_wrapped[ssl_pkg::HEAD_W-1:0];
    end
  end

endmodule

[rtl/ssl_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit resolved per stage.
// Depends on ssl_pkg for widths.
module ssl_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ssl_pkg::SUM_W-1:0]   radicand,
  output logic [ssl_pkg::ROOT_W-1:0]  root
);

  localparam int RW  = ssl_pkg::ROOT_W;
  localparam int SW  = ssl_pkg::SUM_W;
  localparam int RMW = RW + 3;

  logic [SW-1:0]  rad_q  [RW];
  logic [RMW-1:0] rem_q  [RW];
  logic [RW-1:0]  root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [SW-1:0]  rad_in;
    logic [RMW-1:0] rem_in;
    logic [RW-1:0]  root_in;
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rad_in  = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_in[RMW-3:0], rad_in[SW-1:SW-2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k]  <= {rad_in[SW-3:0], 2'b00};
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[RW-2:0], ge};
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

[rtl/ssl_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// The quotient is assumed to fit in Q_W bits. Depends on ssl_pkg.
module ssl_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ssl_pkg::PROD_W-1:0]  num,
  input  logic [ssl_pkg::ROOT_W-1:0]  den,
  output logic [ssl_pkg::Q_W-1:0]     quo
);

  localparam int QW  = ssl_pkg::Q_W;
  localparam int DW  = ssl_pkg::ROOT_W;
  localparam int NW  = ssl_pkg::PROD_W;
  localparam int RMW = DW + 1;

  logic [QW-1:0] low_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [QW-1:0]  low_in;
    logic [DW-1:0]  den_in;
    logic [DW-1:0]  rem_in;
    logic [QW-1:0]  quo_in;
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] rem_sub;
    logic           ge;

    if (k == 0) begin : g_first
      // Upper numerator bits sit below the divisor, as the quotient is narrow
      assign rem_in = DW'(num[NW-1:QW]);
      assign low_in = num[QW-1:0];
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // Bring down one numerator bit and subtract where it fits
    assign rem_sh  = {rem_in, low_in[QW-1]};
    assign ge      = rem_sh >= {1'b0, den_in};
    assign rem_sub = rem_sh - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        low_q[k] <= {low_in[QW-2:0], 1'b0};
        den_q[k] <= den_in;
        rem_q[k] <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        quo_q[k] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

[rtl/setpoint_step_limiter.sv]
`timescale 1ns / 1ps
// Setpoint step limiter top level. The pipeline has 4 arithmetic stages,
// 33 root stages, 32 divider stages and an output register.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits at the output. Reset (rst, synchronous) empties the pipeline and
// loads the default limits 0.8 m and 30 degrees.
// Depends on ssl_pkg, ssl_if, ssl_yaw, ssl_sqrt and ssl_div.
module setpoint_step_limiter (
  input  logic      clk,
  input  logic      rst,
  ssl_in_if.sink    setpoint,
  ssl_out_if.source result,
  ssl_cfg_if.sink   cfg
);

  localparam int POS_W  = ssl_pkg::POS_W;
  localparam int MAG_W  = ssl_pkg::MAG_W;
  localparam int LAT    = ssl_pkg::PIPE_LAT;
  localparam int SUM_W  = ssl_pkg::SUM_W;

  logic [ssl_pkg::LIM_W-1:0]  step_length_limit;
  logic [ssl_pkg::YLIM_W-1:0] yaw_step_limit;
  logic                       en;
  logic [LAT-1:0]             vld;

  // Configuration registers, writes taken at once
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      step_length_limit <= ssl_pkg::STEP_LIMIT_RESET;
      yaw_step_limit    <= ssl_pkg::YAW_LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        ssl_pkg::CFG_STEP_LENGTH_LIMIT: step_length_limit <= cfg.data[ssl_pkg::LIM_W-1:0];
        ssl_pkg::CFG_YAW_STEP_LIMIT:    yaw_step_limit    <= cfg.data[ssl_pkg::YLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance everything unless a finished result is held
  assign en             = !result.valid || result.ready;
  assign setpoint.ready = en;
  assign result.valid   = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], setpoint.valid};
    end
  end

  // Stage 1: per-axis difference, magnitude and sign
  logic [2:0][POS_W-1:0] in_goal, in_now;
  logic [2:0][MAG_W-1:0] s1_mag;
  logic [2:0]            s1_neg;
  logic [2:0][POS_W-1:0] s1_goal, s1_now;

  assign in_goal = {setpoint.data.goal_z, setpoint.data.goal_y, setpoint.data.goal_x};
  assign in_now  = {setpoint.data.now_z, setpoint.data.now_y, setpoint.data.now_x};

  for (genvar i = 0; i < 3; i++) begin : g_diff
    logic signed [POS_W:0] d;
    assign d = $signed({in_goal[i][POS_W-1], in_goal[i]})
             - $signed({in_now[i][POS_W-1], in_now[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        s1_mag[i] <= d[POS_W] ? MAG_W'(-d) : MAG_W'(d);
        s1_neg[i] <= d[POS_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_goal <= in_goal;
      s1_now  <= in_now;
    end
  end

  // Yaw path lands alongside stage 2
  logic signed [ssl_pkg::HEAD_W-1:0] s2_heading;
  ssl_yaw u_yaw (
    .clk          (clk),
    .en           (en),
    .goal_heading (setpoint.data.goal_heading),
    .now_heading  (setpoint.data.now_heading),
    .yaw_limit    (yaw_step_limit),
    .heading      (s2_heading)
  );

  // Stage 2: squares, scaled magnitudes and squared limit
  logic [2:0][ssl_pkg::SQ_W-1:0]   s2_sq;
  logic [2:0][ssl_pkg::PROD_W-1:0] s2_prod;
  logic [ssl_pkg::LIM2_W-1:0]      s2_lim2;
  logic [2:0][POS_W-1:0]           s2_goal, s2_now;
  logic [2:0]                      s2_neg;

  for (genvar i = 0; i < 3; i++) begin : g_mul
    always_ff @(posedge clk) begin
      if (en) begin
        s2_sq[i]   <= s1_mag[i] * s1_mag[i];
        s2_prod[i] <= s1_mag[i] * step_length_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_lim2 <= step_length_limit * step_length_limit;
      s2_goal <= s1_goal;
      s2_now  <= s1_now;
      s2_neg  <= s1_neg;
    end
  end

  // Stage 3: sum of squares
  logic [SUM_W-1:0]           s3_sum;
  logic [ssl_pkg::LIM2_W-1:0] s3_lim2;
  ssl_pkg::side_t             s3_side;
  ssl_pkg::side_t             s3_side_next;

  always_comb begin
    s3_side_next.goal      = s2_goal;
    s3_side_next.now       = s2_now;
    s3_side_next.neg       = s2_neg;
    s3_side_next.heading   = s2_heading;
    s3_side_next.take_goal = 1'b0;
    s3_side_next.prod      = s2_prod;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum  <= SUM_W'(s2_sq[0]) + SUM_W'(s2_sq[1]) + SUM_W'(s2_sq[2]);
      s3_lim2 <= s2_lim2;
      s3_side <= s3_side_next;
    end
  end

  // Stage 4: decide whether the goal is within reach
  logic [SUM_W-1:0] s4_sum;
  ssl_pkg::side_t   s4_side;
  ssl_pkg::side_t   s4_side_next;

  always_comb begin
    s4_side_next           = s3_side;
    s4_side_next.take_goal = s3_sum <= SUM_W'(s3_lim2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sum  <= s3_sum;
      s4_side <= s4_side_next;
    end
  end

  // Root pipeline with its side data
  logic [ssl_pkg::ROOT_W-1:0] root;
  ssl_pkg::side_t             sq_side [ssl_pkg::SQRT_LAT];

  ssl_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (s4_sum),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= s4_side;
      for (int k = 1; k < ssl_pkg::SQRT_LAT; k++) begin
        sq_side[k] <= sq_side[k-1];
      end
    end
  end

  // Divider pipelines, one per axis, with the side data
  logic [2:0][ssl_pkg::Q_W-1:0] quo;
  ssl_pkg::side_t               dv_side [ssl_pkg::DIV_LAT];
  ssl_pkg::side_t               sq_last;

  assign sq_last = sq_side[ssl_pkg::SQRT_LAT-1];

  for (genvar i = 0; i < 3; i++) begin : g_div
    ssl_div u_div (
      .clk (clk),
      .en  (en),
      .num (sq_last.prod[i]),
      .den (root),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= sq_last;
      for (int k = 1; k < ssl_pkg::DIV_LAT; k++) begin
        dv_side[k] <= dv_side[k-1];
      end
    end
  end

  // Output stage: goal, or current position plus the signed step, saturated
  ssl_pkg::side_t        dv_last;
  logic [2:0][POS_W-1:0] pos;

  assign dv_last = dv_side[ssl_pkg::DIV_LAT-1];

  for (genvar i = 0; i < 3; i++) begin : g_out
    logic signed [POS_W+1:0] step;
    logic signed [POS_W+1:0] sum;
    always_comb begin
      step = $signed({2'b00, quo[i]});
      if (dv_last.neg[i]) begin
        step = -step;
      end
      sum = $signed({{2{dv_last.now[i][POS_W-1]}}, dv_last.now[i]}) + step;
      if (dv_last.take_goal) begin
        pos[i] = dv_last.goal[i];
      end else if (sum[POS_W+1:POS_W-1] != {3{sum[POS_W+1]}}) begin
        pos[i] = sum[POS_W+1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
        pos[i] = sum[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.data.out_x       <= pos[0];
      result.data.out_y       <= pos[1];
      result.data.out_z       <= pos[2];
      result.data.out_heading <= dv_last.heading;
    end
  end

  // Checks
  a_enter: assert property (@(posedge clk) disable iff (rst)
    en && setpoint.valid |=> vld[0])
    else $error("accepted item did not enter the pipeline");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");

  a_heading: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.data.out_heading > -16'sd25736)
                  && (result.data.out_heading <= 16'sd25736))
    else $error("result yaw outside (-pi, pi]");

endmodule

[dv/setpoint_step_limiter_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for setpoint_step_limiter: random and directed setpoints
// through the pipeline under several limit settings. Depends on ssl_pkg and ssl_if.
module setpoint_step_limiter_tb;

  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 90;
  localparam int PHASE_ITEMS = 285;
  localparam int POS_W  = ssl_pkg::POS_W;
  localparam int HEAD_W = ssl_pkg::HEAD_W;
  localparam int LIM_W  = ssl_pkg::LIM_W;
  localparam int YLIM_W = ssl_pkg::YLIM_W;

  logic clk;
  logic rst;

  ssl_in_if  sp_if ();
  ssl_out_if res_if ();
  ssl_cfg_if cfg_if ();

  setpoint_step_limiter u_top (
    .clk      (clk),
    .rst      (rst),
    .setpoint (sp_if),
    .result   (res_if),
    .cfg      (cfg_if)
  );

  // Limits as the block should hold them
  logic [LIM_W-1:0]  step_cap;
  logic [YLIM_W-1:0] yaw_cap;

  ssl_pkg::in_item_t  pending_setpoints[$];
  ssl_pkg::out_item_t expected_setpoints[$];
  int errors = 0;
  int in_count = 0;
  int out_count = 0;
  int cfg_count;
  int idle_cycles = 0;
  int hold_left;
  bit hold_done;
  bit no_idle;
  int send_gap;
  int recv_gap;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wrap a yaw into (-pi, pi]
  function automatic int wrap_yaw(int a);
    int r;
    r = a;
    while (r > 25736) r -= 51472;
    while (r <= -25736) r += 51472;
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (POS_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[POS_W-1:0];
    if (v < lo) return lo[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

  // Expected limited setpoint for one goal / current pair
  function automatic ssl_pkg::out_item_t limit_setpoint(ssl_pkg::in_item_t it);
    logic signed [63:0] g [3];
    logic signed [63:0] n [3];
    logic signed [63:0] d [3];
    logic [127:0] mag [3];
    logic [127:0] s;
    logic [127:0] len;
    logic [127:0] t;
    logic [127:0] q;
    logic signed [POS_W-1:0] res [3];
    int diff;
    int head;
    int lim;
    ssl_pkg::out_item_t o;
    g[0] = it.goal_x; g[1] = it.goal_y; g[2] = it.goal_z;
    n[0] = it.now_x;  n[1] = it.now_y;  n[2] = it.now_z;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = g[i] - n[i];
      mag[i] = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
      s = s + mag[i] * mag[i];
    end
    if (s <= 128'(step_cap) * 128'(step_cap)) begin
      for (int i = 0; i < 3; i++) res[i] = clamp_pos(g[i]);
    end else begin
      len = '0;
      for (int b = 50; b >= 0; b--) begin
        t = len | (128'd1 << b);
        if (t * t <= s) len = t;
      end
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] * 128'(step_cap)) / len;
        if (d[i] < 0) res[i] = clamp_pos(n[i] - $signed(q[63:0]));
        else res[i] = clamp_pos(n[i] + $signed(q[63:0]));
      end
    end
    o.out_x = res[0];
    o.out_y = res[1];
    o.out_z = res[2];
    head = int'(it.now_heading);
    diff = wrap_yaw(int'(it.goal_heading) - head);
    lim = int'(yaw_cap);
    if (diff > lim) diff = lim;
    if (diff < -lim) diff = -lim;
    head = wrap_yaw(head + diff);
    o.out_heading = head[HEAD_W-1:0];
    return o;
  endfunction

  // Gap lengths: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic signed [HEAD_W-1:0] rand_heading();
    if ($urandom_range(0, 4) == 0) return HEAD_W'($urandom);
    return HEAD_W'(int'($urandom_range(0, 51472)) - 25736);
  endfunction

  // Mostly goals near the current position, some far, some identical
  function automatic ssl_pkg::in_item_t rand_setpoint();
    ssl_pkg::in_item_t it;
    int mode;
    int sh;
    mode = $urandom_range(0, 9);
    it.now_x = $urandom;
    it.now_y = $urandom;
    it.now_z = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      it.now_x = it.now_x >>> $urandom_range(8, 31);
      it.now_y = it.now_y >>> $urandom_range(8, 31);
      it.now_z = it.now_z >>> $urandom_range(8, 31);
    end
    if (mode == 0) begin
      it.goal_x = $urandom;
      it.goal_y = $urandom;
      it.goal_z = $urandom;
    end else if (mode == 1) begin
      it.goal_x = it.now_x;
      it.goal_y = it.now_y;
      it.goal_z = it.now_z;
    end else begin
      sh = $urandom_range(6, 31);
      it.goal_x = it.now_x + ($signed($urandom) >>> sh);
      it.goal_y = it.now_y + ($signed($urandom) >>> sh);
      it.goal_z = it.now_z + ($signed($urandom) >>> sh);
    end
    it.goal_heading = rand_heading();
    it.now_heading = rand_heading();
    return it;
  endfunction

  function automatic ssl_pkg::in_item_t make_setpoint(int gx, int gy, int gz, int gh,
                                                      int nx, int ny, int nz, int nh);
    ssl_pkg::in_item_t it;
    it.goal_x = gx; it.goal_y = gy; it.goal_z = gz; it.goal_heading = gh[15:0];
    it.now_x = nx;  it.now_y = ny;  it.now_z = nz;  it.now_heading = nh[15:0];
    return it;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d, %s: got %h, want %h", out_count, field, got, want);
    errors++;
  endtask

  // Drive one register write and track it
  task automatic write_limit(logic [ssl_pkg::CFG_IDX_W-1:0] idx,
                             logic [ssl_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == ssl_pkg::CFG_STEP_LENGTH_LIMIT) step_cap = val[LIM_W-1:0];
    else if (idx == ssl_pkg::CFG_YAW_STEP_LIMIT) yaw_cap = val[YLIM_W-1:0];
    cfg_count++;
    cfg_if.valid <= 1'b0;
  endtask

  // Hold the sender until every result is back and the pipeline is empty
  task automatic drain();
    wait (pending_setpoints.size() == 0 && expected_setpoints.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) pending_setpoints.push_back(rand_setpoint());
  endtask

  // Setpoint driver: present the head of the queue, advance on acceptance
  always @(posedge clk) begin
    if (rst) begin
      sp_if.valid <= 1'b0;
      sp_if.data <= '0;
      send_gap <= 0;
    end else if (sp_if.valid && !sp_if.ready) begin
      sp_if.valid <= 1'b1;
    end else begin
      if (sp_if.valid && sp_if.ready) begin
        expected_setpoints.push_back(limit_setpoint(pending_setpoints.pop_front()));
        in_count++;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        sp_if.valid <= 1'b0;
      end else if (pending_setpoints.size() > 0) begin
        sp_if.valid <= 1'b1;
        sp_if.data <= pending_setpoints[0];
        send_gap <= pick_gap();
      end else begin
        sp_if.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once, to fill the pipeline
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && in_count >= 400) begin
      hold_left <= 500;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: check each item against the oldest expectation
  always @(posedge clk) begin
    ssl_pkg::out_item_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_setpoints.size() == 0) begin
          report_mismatch("unexpected item", res_if.data.out_x, 32'd0);
        end else begin
          want = expected_setpoints.pop_front();
          if (res_if.data.out_x !== want.out_x)
            report_mismatch("out_x", res_if.data.out_x, want.out_x);
          if (res_if.data.out_y !== want.out_y)
            report_mismatch("out_y", res_if.data.out_y, want.out_y);
          if (res_if.data.out_z !== want.out_z)
            report_mismatch("out_z", res_if.data.out_z, want.out_z);
          if (res_if.data.out_heading !== want.out_heading)
            report_mismatch("out_heading", 32'(res_if.data.out_heading),
                            32'(want.out_heading));
        end
        out_count++;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (sp_if.valid && sp_if.ready) || (res_if.valid && res_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
      $display("setpoint_step_limiter test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus phases
  initial begin
    cfg_count = 0;
    no_idle = 1'b0;
    step_cap = ssl_pkg::STEP_LIMIT_RESET;
    yaw_cap = ssl_pkg::YAW_LIMIT_RESET;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Default limits: field extremes and special cases
    pending_setpoints.push_back(make_setpoint(0, 0, 0, 0, 0, 0, 0, 0));
    pending_setpoints.push_back(make_setpoint(1000, -2000, 3000, 100,
                                              1000, -2000, 3000, -100));
    pending_setpoints.push_back(make_setpoint(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                              25736, 32'h80000000, 32'h80000000,
                                              32'h80000000, -25735));
    pending_setpoints.push_back(make_setpoint(32'h80000000, 32'h80000000, 32'h80000000,
                                              -25735, 32'h7fffffff, 32'h7fffffff,
                                              32'h7fffffff, 25736));
    pending_setpoints.push_back(make_setpoint(52429, 0, 0, 25736, 0, 0, 0, -25735));
    pending_setpoints.push_back(make_setpoint(52430, 0, 0, -25735, 0, 0, 0, 25736));
    pending_setpoints.push_back(make_setpoint(-1, -1, -1, 32767, 0, 0, 0, -32768));
    pending_setpoints.push_back(make_setpoint(0, 0, 0, -32768, -1, -1, -1, 32767));
    pending_setpoints.push_back(make_setpoint(32'h7fffffff, 0, 0, 4289, 32'h7fff0000,
                                              0, 0, 0));
    pending_setpoints.push_back(make_setpoint(32'h80000000, 0, 0, -4290,
                                              32'h80010000, 0, 0, 0));
    pending_setpoints.push_back(make_setpoint(65536, 65536, 65536, 20000,
                                              0, 0, 0, -20000));
    queue_random(PHASE_ITEMS);
    drain();

    // Zero limits: position and yaw held; ignored indexes too
    write_limit(ssl_pkg::CFG_STEP_LENGTH_LIMIT, 32'd0);
    write_limit(ssl_pkg::CFG_YAW_STEP_LIMIT, 32'd0);
    write_limit(2'd2, $urandom);
    write_limit(2'd3, $urandom);
    pending_setpoints.push_back(make_setpoint(5, 5, 5, 300, 0, 0, 0, 0));
    pending_setpoints.push_back(make_setpoint(7, 7, 7, 0, 7, 7, 7, 25736));
    queue_random(PHASE_ITEMS);
    drain();

    // Largest limits, with no idling on the sender or receiver
    write_limit(ssl_pkg::CFG_STEP_LENGTH_LIMIT, 32'hffffffff);
    write_limit(ssl_pkg::CFG_YAW_STEP_LIMIT, 32'd25736);
    no_idle = 1'b1;
    pending_setpoints.push_back(make_setpoint(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                              25736, 32'h80000000, 32'h80000000,
                                              32'h80000000, -25735));
    queue_random(PHASE_ITEMS);
    drain();
    no_idle = 1'b0;

    // Yaw limit beyond pi and a tiny length limit
    write_limit(ssl_pkg::CFG_STEP_LENGTH_LIMIT, 32'd1);
    write_limit(ssl_pkg::CFG_YAW_STEP_LIMIT, 32'h7fff);
    queue_random(PHASE_ITEMS);
    drain();

    // Random settings
    for (int p = 0; p < 2; p++) begin
      write_limit(ssl_pkg::CFG_STEP_LENGTH_LIMIT, $urandom >> $urandom_range(0, 20));
      write_limit(ssl_pkg::CFG_YAW_STEP_LIMIT, $urandom_range(0, 32767));
      queue_random(PHASE_ITEMS);
      drain();
    end

    $display("%0d setpoints checked over %0d register writes and six limit settings",
             out_count, cfg_count);
    $display("including zero, largest and random limits with a long result stall");
    if (errors == 0) begin
      $display("setpoint_step_limiter test passed");
    end else begin
      $display("setpoint_step_limiter test failed");
    end
    $finish;
  end

endmodule
